// ===== src/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge, ignored while reset is high.
`define ASSERT_DIS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Check a property on every clock edge, including during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) \
      else $error(msg);

`endif

// ===== src/fhpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fhpa_pkg
// Types and codes for the handle pool allocator: the request and response
// transaction layouts, operation codes and status codes.
// ----------------------------------------------------------------------------
package fhpa_pkg;

   localparam int HANDLE_W          = 6;
   localparam int HANDLE_SPACE      = 64;
   localparam int POOL_SIZE_DEFAULT = 64;

   localparam logic [1:0] MODE_ALLOC = 2'd0;
   localparam logic [1:0] MODE_TRY   = 2'd1;
   localparam logic [1:0] MODE_FREE  = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_FREED  = 2'd1;
   localparam logic [1:0] ST_NOT_ALLOC = 2'd2;
   localparam logic [1:0] ST_EXHAUSTED = 2'd3;

   typedef struct packed {
      logic [1:0]          mode;
      logic [HANDLE_W-1:0] release_handle;
   } req_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] granted_handle;
      logic [1:0]          status;
   } rsp_type;

endpackage

// ===== src/fifo_handle_pool_allocator_top.sv =====
// ----------------------------------------------------------------------------
// fifo_handle_pool_allocator_top
// Hands out small integer handles, reusing freed ones in first-in first-out
// order and minting fresh ones while the pool has room.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one operation per transaction: allocate, try
//   allocate (reuse a freed handle only) or deallocate. Every request gives
//   exactly one transaction on the rsp channel with a handle and a status.
//   Both channels use valid/stall; a transaction moves when valid is high
//   and stall is low.
//   A request passes through the input register and then the response register.
//   One request is taken every cycle unless the response stalls;
//   the rate is set by the single read port of the freed-handle memory, whose
//   registered read of the next head entry is ready by the following cycle.
//   When the receiver stalls, the response holds, the input register fills,
//   and req_stall rises until the response is taken.
//   Reset clears the allocated map (one flip-flop per handle), the FIFO
//   pointers and the mint counter together; no clearing pass runs.
//   Freed-handle memory contents are only used after being written.
// ----------------------------------------------------------------------------
module fifo_handle_pool_allocator_top
   import fhpa_pkg::*;
#(
   parameter int POOL_SIZE = POOL_SIZE_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Handles are 6 bits wide, so at most 64 can ever exist.
   localparam int MINT_LIMIT = (POOL_SIZE < HANDLE_SPACE) ? POOL_SIZE : HANDLE_SPACE;
   localparam int IDX_W      = $clog2(MINT_LIMIT);
   localparam int CNT_W      = $clog2(MINT_LIMIT + 1);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(MINT_LIMIT - 1);
   localparam logic [CNT_W-1:0] MINT_MAX  = CNT_W'(MINT_LIMIT);
   localparam logic [HANDLE_W:0] REL_LIM  = (HANDLE_W + 1)'(MINT_LIMIT);

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
      return (i == LAST_IDX) ? '0 : i + 1'b1;
   endfunction

   // Pipeline control.
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    s1_fire;
   logic    req_accept;

   // Pool state.
   logic [MINT_LIMIT-1:0] map_ff, map_in;
   logic [IDX_W-1:0]      head_ff, head_in;
   logic [IDX_W-1:0]      tail_ff, tail_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      minted_ff, minted_in;
   logic [HANDLE_W-1:0]   head_data_ff;
   logic [HANDLE_W-1:0]   fifo_mem [MINT_LIMIT];
   logic                  wr_en;
   logic                  rel_ok;
   logic [IDX_W-1:0]      rel_idx;

   // Advance the input register whenever the response register is free or
   // is being drained this cycle.
   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_fire;
   assign req_accept = req_valid && !req_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      s1_valid_in = req_accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rel_ok  = {1'b0, s1_ff.release_handle} < REL_LIM;
   assign rel_idx = s1_ff.release_handle[IDX_W-1:0];

   // One operation per fired request: touch at most one map bit, one FIFO slot
   // and the counters.
   always_comb begin
      map_in                = map_ff;
      head_in               = head_ff;
      tail_in               = tail_ff;
      count_in              = count_ff;
      minted_in             = minted_ff;
      wr_en                 = 1'b0;
      rsp_in.granted_handle = '0;
      rsp_in.status         = ST_OK;
      if (s1_fire) begin
         case (s1_ff.mode)
            MODE_ALLOC, MODE_TRY: begin
               if (count_ff != '0) begin
                  // Reuse the oldest freed handle.
                  rsp_in.granted_handle            = head_data_ff;
                  map_in[head_data_ff[IDX_W-1:0]] = 1'b1;
                  head_in                          = next_slot(head_ff);
                  count_in                         = count_ff - 1'b1;
               end else if (s1_ff.mode == MODE_TRY) begin
                  rsp_in.status = ST_NO_FREED;
               end else if (minted_ff < MINT_MAX) begin
                  rsp_in.granted_handle          = HANDLE_W'(minted_ff);
                  map_in[minted_ff[IDX_W-1:0]] = 1'b1;
                  minted_in                      = minted_ff + 1'b1;
               end else begin
                  rsp_in.status = ST_EXHAUSTED;
               end
            end
            MODE_FREE: begin
               if (!rel_ok || !map_ff[rel_idx]) begin
                  rsp_in.status = ST_NOT_ALLOC;
               end else begin
                  map_in[rel_idx] = 1'b0;
                  wr_en           = 1'b1;
                  tail_in         = next_slot(tail_ff);
                  count_in        = count_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         map_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         minted_ff    <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         map_ff       <= map_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         minted_ff    <= minted_in;
      end
   end

   // Payload registers: load on transfer, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff <= req_data;
      end
      if (s1_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // Freed-handle memory. Read the entry at the next head every cycle so the
   // oldest handle is registered and ready; bypass a write to that slot.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         fifo_mem[tail_ff] <= s1_ff.release_handle;
      end
      if (wr_en && (tail_ff == head_in)) begin
         head_data_ff <= s1_ff.release_handle;
      end else begin
         head_data_ff <= fifo_mem[head_in];
      end
   end

endmodule

// ===== src/fhpa_checker.sv =====
// ----------------------------------------------------------------------------
// fhpa_checker
// Port-level checks on the handle pool allocator, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fhpa_checker
   import fhpa_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // A stalled response stays offered and unchanged.
   `ASSERT_DIS(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "rsp dropped")
   `ASSERT_DIS(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_data), "rsp changed")
   // Back-pressure on requests only comes from a stalled response.
   `ASSERT_DIS(a_stall_cause, clock, reset, req_stall |-> rsp_valid && rsp_stall, "bad req_stall")
   // The response port shows a valid response after an accepted request.
   `ASSERT_DIS(a_rsp_follows, clock, reset, req_valid && !req_stall |-> ##2 rsp_valid, "rsp missing")
   // Reset empties the response register and drops req_stall.
   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid && !req_stall, "not empty")

endmodule

bind fifo_handle_pool_allocator_top fhpa_checker u_fhpa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
